FILE: rtl/core/greedy_word_wrap_stream_macros.svh
// assertion macros shared by the word wrap rtl
`ifndef GREEDY_WORD_WRAP_STREAM_MACROS_SVH
`define GREEDY_WORD_WRAP_STREAM_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define GWWS_ASSERT_ALWAYS(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("word wrap check failed");
// property that must hold whenever the antecedent is true
`define GWWS_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("word wrap check failed");
`else
`define GWWS_ASSERT_ALWAYS(name, expr)
`define GWWS_ASSERT_IMPLIES(name, ante, cons)
`endif

`endif

FILE: rtl/core/gwws_pkg.sv
// types, character codes and helpers for the word wrap block
package gwws_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_FLUSH
    } state_t;

    localparam int CHAR_W  = 8;
    localparam int LINE_W  = 7;
    localparam int WIDTH_W = 6;

    // largest wrap width that is honoured
    localparam int MAX_WIDTH = 63;

    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [LINE_W-1:0]  line_t;
    typedef logic [WIDTH_W-1:0] wrap_t;

    localparam char_t NUL_CODE     = 8'd0;
    localparam char_t TAB_CODE     = 8'd9;
    localparam char_t NEWLINE_CODE = 8'd10;
    localparam char_t CR_CODE      = 8'd13;
    localparam char_t SPACE_CODE   = 8'd32;

    localparam line_t LINE_ZERO = 7'd0;
    localparam line_t LINE_ONE  = 7'd1;
    localparam line_t LINE_MAX  = 7'd127;

    localparam wrap_t WRAP_RESET = 6'd32;

    // space, tab, vertical tab, form feed, carriage return
    function automatic logic is_blank(input char_t c);
        return (c == SPACE_CODE) ||
               ((c >= TAB_CODE) && (c <= CR_CODE) && (c != NEWLINE_CODE));
    endfunction

    // characters that close a lookahead word
    function automatic logic ends_word(input char_t c);
        return (c == SPACE_CODE) || (c == NEWLINE_CODE) || (c == NUL_CODE);
    endfunction

    // saturating line length increment
    function automatic line_t bump_line(input line_t len);
        return (len == LINE_MAX) ? len : len + LINE_ONE;
    endfunction

endpackage

FILE: rtl/core/gwws_ram.sv
// generic single-port-write ram with registered read
module gwws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/greedy_word_wrap_stream.sv
// greedy word wrap over a byte stream, top level
//
// input channel: in_valid / in_stall with char_in and end_of_text, one byte per word
// output channel: out_valid / out_stall with char_out and last_out, one byte per word
// config: cfg_wr_en writes wrap_width (reset 32); write it only while the block is idle
// a whitespace byte is held in the lookahead ram with the word that follows it until
//   line length plus word length reaches the wrap width (then it leaves as a newline)
//   or the word ends (then it leaves unchanged); end_of_text releases everything
// throughput: a byte that is not held leaves without delay; a byte that releases a burst
//   of held bytes keeps the next byte waiting until the burst has left, the burst leaving
//   at one byte per cycle, unless the receiver stalls, out of the single lookahead ram read port
// path: a byte that is not held passes from the input register to the output register
// last_out marks the final byte of each burst caused by one input word
// reset: line length and held count go to zero, wrap width to 32; no clearing pass,
//   the ram is only ever read below the held count
// a stalled receiver freezes the output register and the drain; one input word can
//   still be taken into the input register while the output waits
module greedy_word_wrap_stream #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [gwws_pkg::WIDTH_W-1:0] wrap_width,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [gwws_pkg::CHAR_W-1:0] char_in,
    input  logic                       end_of_text,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [gwws_pkg::CHAR_W-1:0] char_out,
    output logic                       last_out
);

    `include "greedy_word_wrap_stream_macros.svh"

    // ram address, held-count and sum widths
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int RW = CW + 1;
    localparam int SW = ((CW > gwws_pkg::LINE_W) ? CW : gwws_pkg::LINE_W) + 1;

    // position in the circular lookahead buffer, one compare and subtract
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [RW-1:0] sum;
        sum = RW'(base) + RW'(off);
        if (sum >= RW'(BUFFER_DEPTH))
        begin
            sum = sum - RW'(BUFFER_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // state
    gwws_pkg::state_t state_reg, state_next;
    gwws_pkg::wrap_t  wrap_width_reg;

    logic             item_valid_reg, item_valid_next;
    gwws_pkg::char_t  item_char_reg, item_char_next;
    logic             item_eot_reg, item_eot_next;

    gwws_pkg::line_t  line_reg, line_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    head_reg, head_next;

    // drain context: position, byte count, end of the lookahead word
    logic [CW-1:0]    p_reg, p_next;
    logic [CW-1:0]    n_reg, n_next;
    logic [CW-1:0]    j_reg, j_next;
    logic             eot_reg, eot_next;

    // one byte held back until we know whether it closes the burst
    logic             stage_valid_reg, stage_valid_next;
    gwws_pkg::char_t  stage_char_reg, stage_char_next;

    logic             out_valid_reg, out_valid_next;
    gwws_pkg::char_t  out_char_reg, out_char_next;
    logic             out_last_reg, out_last_next;

    // ram side
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    gwws_pkg::char_t  ram_wdata;
    logic [AW-1:0]    rd_addr;
    gwws_pkg::char_t  rd_data;

    // decode
    logic             out_free;
    logic             item_go;
    logic             pending;
    logic [SW-1:0]    width_eff;
    logic [AW-1:0]    tail_addr;
    logic [CW-1:0]    idle_n, idle_j, idle_word;
    logic             idle_ends;
    logic             idle_release;
    logic             d_go, d_blank, d_wrap, d_hold, d_last_pos;
    logic [CW-1:0]    d_jp, d_word;
    gwws_pkg::char_t  d_char;
    gwws_pkg::line_t  d_line;

    gwws_ram #(
        .WIDTH (gwws_pkg::CHAR_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // effective wrap width, clamped to the supported maximum
    assign width_eff = (SW'(wrap_width_reg) < SW'(gwws_pkg::MAX_WIDTH)) ?
                       SW'(wrap_width_reg) : SW'(gwws_pkg::MAX_WIDTH);

    assign out_free = !out_valid_reg || !out_stall;
    assign pending  = (count_reg != '0);
    assign item_go  = (state_reg == gwws_pkg::ST_IDLE) && item_valid_reg && out_free;
    assign in_stall = item_valid_reg && !item_go;

    // new byte appended behind the held whitespace and its word so far
    assign tail_addr = ring_add(head_reg, count_reg);
    assign idle_n    = count_reg + CW'(1);
    assign idle_ends = gwws_pkg::ends_word(item_char_reg);
    assign idle_j    = idle_ends ? count_reg : idle_n;
    assign idle_word = idle_j - CW'(1);

    // the held whitespace gets its answer now: wrap, word closed, text ended or full
    assign idle_release = pending &&
                          (((SW'(line_reg) + SW'(idle_word)) >= width_eff) ||
                           (idle_n >= CW'(BUFFER_DEPTH)) ||
                           idle_ends || item_eot_reg);

    // drain: one held byte per cycle from the ram read port unless the receiver stalls
    assign d_char     = rd_data;
    assign d_blank    = gwws_pkg::is_blank(d_char);
    assign d_jp       = (p_reg < j_reg) ? j_reg : n_reg;
    assign d_word     = d_jp - p_reg - CW'(1);
    assign d_wrap     = d_blank &&
                        (((SW'(line_reg) + SW'(d_word)) >= width_eff) ||
                         ((n_reg - p_reg) >= CW'(BUFFER_DEPTH)));
    assign d_hold     = d_blank && !d_wrap && !(d_jp < n_reg) && !eot_reg;
    assign d_last_pos = (p_reg == (n_reg - CW'(1)));
    assign d_line     = ((d_char == gwws_pkg::NEWLINE_CODE) || d_wrap) ?
                        gwws_pkg::LINE_ONE : gwws_pkg::bump_line(line_reg);
    assign d_go       = (state_reg == gwws_pkg::ST_DRAIN) &&
                        (!stage_valid_reg || out_free);

    // read address runs one byte ahead of the drain position
    always_comb
    begin
        unique case (state_reg)
            gwws_pkg::ST_DRAIN:
            begin
                if (d_go && !d_hold)
                begin
                    rd_addr = ring_add(head_reg, p_reg + CW'(1));
                end
                else
                begin
                    rd_addr = ring_add(head_reg, p_reg);
                end
            end
            default:
            begin
                rd_addr = head_reg;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gwws_pkg::ST_IDLE:
            begin
                if (item_go && idle_release)
                begin
                    state_next = gwws_pkg::ST_DRAIN;
                end
            end
            gwws_pkg::ST_DRAIN:
            begin
                if (d_go)
                begin
                    priority if (d_hold)
                    begin
                        state_next = gwws_pkg::ST_IDLE;
                    end
                    else if (d_last_pos)
                    begin
                        state_next = gwws_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        state_next = gwws_pkg::ST_DRAIN;
                    end
                end
            end
            gwws_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = gwws_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gwws_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        item_valid_next  = item_valid_reg;
        item_char_next   = item_char_reg;
        item_eot_next    = item_eot_reg;
        line_next        = line_reg;
        count_next       = count_reg;
        head_next        = head_reg;
        p_next           = p_reg;
        n_next           = n_reg;
        j_next           = j_reg;
        eot_next         = eot_reg;
        stage_valid_next = stage_valid_reg;
        stage_char_next  = stage_char_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_char_next    = out_char_reg;
        out_last_next    = out_last_reg;
        ram_we           = 1'b0;
        ram_waddr        = tail_addr;
        ram_wdata        = item_char_reg;

        unique case (state_reg)
            gwws_pkg::ST_IDLE:
            begin
                if (item_go)
                begin
                    item_valid_next = 1'b0;
                    if (!pending)
                    begin
                        // nothing held: decide this byte on its own
                        priority if (item_char_reg == gwws_pkg::NEWLINE_CODE)
                        begin
                            out_valid_next = 1'b1;
                            out_char_next  = item_char_reg;
                            out_last_next  = 1'b1;
                            line_next      = gwws_pkg::LINE_ONE;
                        end
                        else if (gwws_pkg::is_blank(item_char_reg))
                        begin
                            if (SW'(line_reg) >= width_eff)
                            begin
                                out_valid_next = 1'b1;
                                out_char_next  = gwws_pkg::NEWLINE_CODE;
                                out_last_next  = 1'b1;
                                line_next      = gwws_pkg::LINE_ONE;
                            end
                            else if (item_eot_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_char_next  = item_char_reg;
                                out_last_next  = 1'b1;
                                line_next      = gwws_pkg::bump_line(line_reg);
                            end
                            else
                            begin
                                // hold the whitespace until its word is known
                                ram_we     = 1'b1;
                                ram_waddr  = head_reg;
                                count_next = CW'(1);
                            end
                        end
                        else
                        begin
                            out_valid_next = 1'b1;
                            out_char_next  = item_char_reg;
                            out_last_next  = 1'b1;
                            line_next      = gwws_pkg::bump_line(line_reg);
                        end
                        if (item_eot_reg)
                        begin
                            line_next = gwws_pkg::LINE_ZERO;
                        end
                    end
                    else
                    begin
                        ram_we = 1'b1;
                        if (idle_release)
                        begin
                            p_next   = '0;
                            n_next   = idle_n;
                            j_next   = idle_j;
                            eot_next = item_eot_reg;
                        end
                        else
                        begin
                            count_next = idle_n;
                        end
                    end
                end
            end
            gwws_pkg::ST_DRAIN:
            begin
                if (d_go)
                begin
                    if (d_hold)
                    begin
                        // a whitespace inside the word waits again; close the burst
                        if (stage_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_char_next  = stage_char_reg;
                            out_last_next  = 1'b1;
                        end
                        stage_valid_next = 1'b0;
                        head_next        = ring_add(head_reg, p_reg);
                        count_next       = n_reg - p_reg;
                    end
                    else
                    begin
                        if (stage_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_char_next  = stage_char_reg;
                            out_last_next  = 1'b0;
                        end
                        stage_valid_next = 1'b1;
                        stage_char_next  = d_wrap ? gwws_pkg::NEWLINE_CODE : d_char;
                        line_next        = d_line;
                        p_next           = p_reg + CW'(1);
                        if (d_last_pos)
                        begin
                            count_next = '0;
                            if (eot_reg)
                            begin
                                line_next = gwws_pkg::LINE_ZERO;
                            end
                        end
                    end
                end
            end
            gwws_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_char_next    = stage_char_reg;
                    out_last_next    = 1'b1;
                    stage_valid_next = 1'b0;
                end
            end
            default:
            begin
                stage_valid_next = 1'b0;
            end
        endcase

        // input register takes a new word whenever it is free or being emptied
        if (in_valid && !in_stall)
        begin
            item_valid_next = 1'b1;
            item_char_next  = char_in;
            item_eot_next   = end_of_text;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= gwws_pkg::ST_IDLE;
            wrap_width_reg  <= gwws_pkg::WRAP_RESET;
            item_valid_reg  <= 1'b0;
            line_reg        <= gwws_pkg::LINE_ZERO;
            count_reg       <= '0;
            head_reg        <= '0;
            p_reg           <= '0;
            n_reg           <= '0;
            j_reg           <= '0;
            eot_reg         <= 1'b0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            item_valid_reg  <= item_valid_next;
            line_reg        <= line_next;
            count_reg       <= count_next;
            head_reg        <= head_next;
            p_reg           <= p_next;
            n_reg           <= n_next;
            j_reg           <= j_next;
            eot_reg         <= eot_next;
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_wr_en)
            begin
                wrap_width_reg <= wrap_width;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_char_reg  <= item_char_next;
        item_eot_reg   <= item_eot_next;
        stage_char_reg <= stage_char_next;
        out_char_reg   <= out_char_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign char_out  = out_char_reg;
    assign last_out  = out_last_reg;

    // held bytes never fill the ram
    `GWWS_ASSERT_ALWAYS(a_count_below_depth, count_reg < CW'(BUFFER_DEPTH))
    // drain position stays inside the burst
    `GWWS_ASSERT_IMPLIES(a_drain_pos_in_range, state_reg == gwws_pkg::ST_DRAIN, p_reg < n_reg)
    // staged byte never outlives its burst
    `GWWS_ASSERT_IMPLIES(a_stage_empty_in_idle, state_reg == gwws_pkg::ST_IDLE, !stage_valid_reg)
    // flush always has a byte to close the burst
    `GWWS_ASSERT_IMPLIES(a_flush_has_byte, state_reg == gwws_pkg::ST_FLUSH, stage_valid_reg)

endmodule

FILE: dv/tb_greedy_word_wrap_stream.sv
// self-checking testbench for the greedy word wrap stream block
`timescale 1ns / 100ps

module tb_greedy_word_wrap_stream;

    import gwws_pkg::*;

    // lookahead ram depth, matches the rtl default
    localparam int BUF_DEPTH = 64;
    // wait that covers the drain of a full lookahead store, with margin
    localparam int DRAIN_CYCLES = 80;
    // cycles with no word taken on either side before the run is abandoned
    localparam int WATCHDOG_LIMIT = 3000;
    // length of the forced receiver hold-off
    localparam int HOLD_CYCLES = 400;

    // whitespace codes the package does not name
    localparam char_t VT_CODE = 8'd11;
    localparam char_t FF_CODE = 8'd12;

    typedef struct packed {
        char_t ch;
        logic  last;
    } wrapped_byte_t;

    logic  clk;
    logic  rst_n;
    logic  cfg_wr_en;
    wrap_t wrap_width;
    logic  in_valid;
    logic  in_stall;
    char_t char_in;
    logic  end_of_text;
    logic  out_valid;
    logic  out_stall;
    char_t char_out;
    logic  last_out;

    // predictor state: current line length, lookahead store and wrap width
    line_t line_len;
    char_t held_bytes [0:BUF_DEPTH-1];
    int    held_cnt;
    wrap_t line_limit;

    // bytes still owed by the block, oldest first
    wrapped_byte_t pending_bytes [$];

    int   mismatches;
    int   quiet_cycles;
    int   tx_idle_pct;
    int   rx_stall_pct;
    logic hold_req;

    greedy_word_wrap_stream u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .wrap_width (wrap_width),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_in    (char_in),
        .end_of_text(end_of_text),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .char_out   (char_out),
        .last_out   (last_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // works out the bytes released by one accepted word and queues them
    function automatic void wrap_predict(input char_t c, input logic eot);
        int            eff_w;
        int            n;
        int            pos;
        int            j;
        int            k;
        int            run_len;
        char_t         b;
        char_t         o;
        logic          held_back;
        wrapped_byte_t burst [$];

        eff_w = (int'(line_limit) < MAX_WIDTH) ? int'(line_limit) : MAX_WIDTH;
        if (held_cnt >= BUF_DEPTH)
            held_cnt = BUF_DEPTH - 1;
        held_bytes[held_cnt] = c;
        n = held_cnt + 1;
        pos = 0;
        held_back = 1'b0;

        while (pos < n && !held_back)
        begin
            b = held_bytes[pos];
            o = b;
            if (b == NEWLINE_CODE)
                line_len = LINE_ONE;
            else if (b == SPACE_CODE || (b >= TAB_CODE && b <= CR_CODE))
            begin
                // length of the text word after the blank, up to space, newline or nul
                j = pos + 1;
                while (j < n && held_bytes[j] != SPACE_CODE &&
                       held_bytes[j] != NEWLINE_CODE && held_bytes[j] != NUL_CODE)
                    j++;
                run_len = j - pos - 1;
                if (int'(line_len) + run_len >= eff_w || n - pos >= BUF_DEPTH)
                begin
                    o = NEWLINE_CODE;
                    line_len = LINE_ONE;
                end
                else if (j < n || eot)
                begin
                    if (line_len != LINE_MAX)
                        line_len = line_len + LINE_ONE;
                end
                else
                    held_back = 1'b1;
            end
            else if (line_len != LINE_MAX)
                line_len = line_len + LINE_ONE;

            if (!held_back)
            begin
                burst.push_back('{ch: o, last: 1'b0});
                pos++;
            end
        end

        for (k = 0; k < n - pos; k++)
            held_bytes[k] = held_bytes[pos + k];
        held_cnt = n - pos;

        // end of text starts a fresh line count for the next text
        if (eot)
            line_len = LINE_ZERO;
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i])
            pending_bytes.push_back(burst[i]);
    endfunction

    // offers one byte, with random idle gaps before it, and waits for it to be taken
    task automatic send_char(input char_t c, input logic eot);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        char_in     <= c;
        end_of_text <= eot;
        @(posedge clk);
        // in_stall read here is the value the block presented at this edge
        while (in_stall)
            @(posedge clk);
        wrap_predict(c, eot);
    endtask

    // sender stops until every owed byte has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_bytes.size() != 0);
    endtask

    // new wrap width, only once the block has nothing held and nothing owed
    task automatic write_width(input wrap_t w);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en  <= 1'b1;
        wrap_width <= w;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        line_limit = w;
    endtask

    // well-formed text: runs of printable bytes split by separators, ending the text
    task automatic send_text(input int n_items);
        int    sent;
        int    run_len;
        int    pick;
        char_t sep;

        sent = 0;
        while (sent < n_items)
        begin
            // mostly short runs of 1 to 8 bytes, now and then one of 10 to 66 bytes
            run_len = ($urandom_range(7) == 0) ? $urandom_range(10, 66) : $urandom_range(1, 8);
            repeat (run_len)
            begin
                send_char(char_t'($urandom_range(33, 126)), 1'b0);
                sent++;
            end
            pick = $urandom_range(99);
            if (pick < 60)
                sep = SPACE_CODE;
            else if (pick < 72)
                sep = NEWLINE_CODE;
            else if (pick < 84)
                sep = char_t'($urandom_range(TAB_CODE, CR_CODE));
            else if (pick < 90)
                sep = NUL_CODE;
            else
                sep = char_t'($urandom_range(255));
            send_char(sep, $urandom_range(19) == 0);
            sent++;
        end
        send_char(char_t'($urandom_range(33, 126)), 1'b1);
    endtask

    // reset width of 32, short text that stays on one line
    task automatic test_default_width();
        send_char("a", 1'b0);
        send_char(SPACE_CODE, 1'b0);
        send_char("b", 1'b1);
    endtask

    // zero width turns every blank into a newline
    task automatic test_zero_width();
        write_width(wrap_t'(0));
        send_char("a", 1'b0);
        send_char(SPACE_CODE, 1'b0);
        send_char("b", 1'b0);
        send_char(TAB_CODE, 1'b0);
        send_char("c", 1'b1);
    endtask

    // nul closes a text word, tab / vt / ff / cr do not, top bit set bytes pass
    task automatic test_special_bytes();
        write_width(wrap_t'(MAX_WIDTH));
        send_char(8'hFF, 1'b0);
        send_char(SPACE_CODE, 1'b0);
        send_char(NUL_CODE, 1'b0);
        send_char(TAB_CODE, 1'b0);
        send_char("x", 1'b0);
        send_char(VT_CODE, 1'b0);
        send_char(FF_CODE, 1'b0);
        send_char(CR_CODE, 1'b0);
        send_char(NEWLINE_CODE, 1'b0);
        send_char(8'h80, 1'b1);
    endtask

    // the wrap fires while the following text word is still arriving
    task automatic test_early_decision();
        write_width(wrap_t'(6));
        send_char("a", 1'b0);
        send_char(SPACE_CODE, 1'b0);
        send_char("b", 1'b0);
        send_char("c", 1'b0);
        send_char("d", 1'b0);
        send_char("e", 1'b0);
        send_char("f", 1'b0);
        send_char("g", 1'b1);
    endtask

    // a line past 127 bytes must saturate, so the blank after it still wraps
    task automatic test_line_saturation();
        write_width(wrap_t'(MAX_WIDTH));
        repeat (131) send_char(char_t'($urandom_range(33, 126)), 1'b0);
        send_char(SPACE_CODE, 1'b0);
        send_char("z", 1'b1);
    endtask

    task automatic test_random_text(input wrap_t w, input int n_items);
        write_width(w);
        send_text(n_items);
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        write_width(wrap_t'(40));
        hold_req = 1'b1;
        send_text(80);
        wait_drained();
    endtask

    // arbitrary bytes and frequent end of text
    task automatic test_noise();
        write_width(wrap_t'(5));
        repeat (30) send_char(char_t'($urandom_range(255)), $urandom_range(9) == 0);
        send_char(char_t'($urandom_range(255)), 1'b1);
    endtask

    // receiver: random stalls, or one long counted hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // output check, field by field against the oldest owed byte
    always @(posedge clk)
    begin : check_out
        wrapped_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word: char_out %0d last_out %0b",
                             char_out, last_out);
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (char_out !== want.ch)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("char_out mismatch: expected %0d, got %0d", want.ch, char_out);
                end
                if (last_out !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("last_out mismatch: expected %0b, got %0b (char %0d)",
                                 want.last, last_out, want.ch);
                end
            end
        end
    end

    // watchdog on silence: no word taken on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        wrap_width   = WRAP_RESET;
        in_valid     = 1'b0;
        char_in      = NUL_CODE;
        end_of_text  = 1'b0;
        hold_req     = 1'b0;
        mismatches   = 0;
        quiet_cycles = 0;
        line_len     = LINE_ZERO;
        held_cnt     = 0;
        line_limit   = WRAP_RESET;

        // first idling pattern: sender a little, receiver a lot
        tx_idle_pct  = 38;
        rx_stall_pct = 77;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_width();
        test_zero_width();
        test_special_bytes();
        test_early_decision();
        test_random_text(wrap_t'(1), 70);

        // the other way round
        tx_idle_pct  = 77;
        rx_stall_pct = 38;
        test_random_text(WRAP_RESET, 70);
        test_line_saturation();

        // no idling on either side
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        test_random_text(wrap_t'($urandom_range(2, 62)), 70);
        test_backpressure();
        test_noise();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_bytes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: greedy_word_wrap_stream.f
+incdir+rtl/core
rtl/core/gwws_pkg.sv
rtl/core/gwws_ram.sv
rtl/core/greedy_word_wrap_stream.sv
dv/tb_greedy_word_wrap_stream.sv
